@@ rtl/core/assert_macros.svh @@
// Assertion macros used by the range allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("assertion failed");
`endif

@@ rtl/core/vra_pkg.sv @@
// Package with the types and constants of the virtual range allocator.
package vra_pkg;

    localparam int MaxRanges = 64;
    localparam int IdxW = $clog2(MaxRanges);
    localparam int CntW = $clog2(MaxRanges + 1);

    localparam logic [1:0] REQ_MAP    = 2'd0;
    localparam logic [1:0] REQ_UNMAP  = 2'd1;
    localparam logic [1:0] REQ_LOOKUP = 2'd2;
    localparam logic [1:0] REQ_RSVD   = 2'd3;

    localparam logic [1:0] MODE_ANY     = 2'd0;
    localparam logic [1:0] MODE_FIXED   = 2'd1;
    localparam logic [1:0] MODE_NOREPL  = 2'd2;
    localparam logic [1:0] MODE_RSVD    = 2'd3;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_INVALID  = 3'd1;
    localparam logic [2:0] ST_NOSPACE  = 3'd2;
    localparam logic [2:0] ST_EXISTS   = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic CFG_LOW  = 1'b0;
    localparam logic CFG_HIGH = 1'b1;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] address;
        logic [63:0] range_length;
        logic [1:0]  placement_mode;
    } req_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] result_start;
        logic [63:0] result_length;
    } rsp_t;

endpackage

@@ rtl/core/virtual_range_allocator.sv @@
// Virtual range allocator: sorted range table with map, unmap and lookup.
// Rejected or unknown requests finish without a scan; unmap and lookup scan the
// stored ranges, and map may scan them for a collision, for a gap and to shift up;
// each scan step issues a read, then uses the data the memories register.
// One transaction at a time: a new input is taken from the cycle after the result is.
// Reset clears the count and low window, sets the high window to all ones; memories need no clearing.
module virtual_range_allocator
    import vra_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  req_t        in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output rsp_t        out_data
);

`include "assert_macros.svh"

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_CHECK = 9'b000000010,
        S_COLL  = 9'b000000100,
        S_FIT   = 9'b000001000,
        S_FITE  = 9'b000010000,
        S_SHIFT = 9'b000100000,
        S_FIND  = 9'b001000000,
        S_DEL   = 9'b010000000,
        S_DONE  = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] starts_mem [MaxRanges];
    logic [63:0] lengths_mem [MaxRanges];
    logic [63:0] rd_start, rd_len;

    logic [63:0] win_low_reg, win_high_reg;
    logic [CntW-1:0] count_reg;
    req_t req_reg;
    rsp_t rsp_reg;
    logic out_valid_reg;

    // Scan index, from which the read address is derived, and a flag that read data is valid.
    logic [CntW-1:0] idx_reg;
    logic rd_ok_reg;
    logic [63:0] cur_reg;
    logic [63:0] place_reg;
    logic hit_reg;

    logic [CntW-1:0] rd_addr;
    logic we;
    logic [IdxW-1:0] wr_addr;
    logic [63:0] wr_start, wr_len;

    logic [63:0] last_req, rd_end;
    logic hint_fits, cur_fits;
    logic collide, coll_end, fit_brk, fit_end, find_hit, shift_more, del_last;

    assign last_req = req_reg.address + (req_reg.range_length - 64'd1);
    assign rd_end   = rd_start + (rd_len - 64'd1);
    assign hint_fits = req_reg.address >= win_low_reg && req_reg.address <= win_high_reg
        && (req_reg.range_length - 64'd1) <= (win_high_reg - req_reg.address);
    assign cur_fits = cur_reg >= win_low_reg && cur_reg <= win_high_reg
        && (req_reg.range_length - 64'd1) <= (win_high_reg - cur_reg);

    // Table memories: one write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            starts_mem[wr_addr]  <= wr_start;
            lengths_mem[wr_addr] <= wr_len;
        end
        rd_start <= starts_mem[rd_addr[IdxW-1:0]];
        rd_len   <= lengths_mem[rd_addr[IdxW-1:0]];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_low_reg  <= '0;
            win_high_reg <= '1;
        end
        else if (cfg_we)
        begin
            if (cfg_index == CFG_LOW)
                win_low_reg <= cfg_data;
            else
                win_high_reg <= cfg_data;
        end
    end

    assign in_stall  = (state_reg != S_IDLE) || out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = rsp_reg;

    // Read address follows the scan index; shifting reads the entry below, deleting the one above.
    always_comb
    begin
        rd_addr = idx_reg;
        if (state_reg == S_SHIFT)
            rd_addr = idx_reg - CntW'(1);
        else if (state_reg == S_DEL)
            rd_addr = idx_reg + CntW'(1);
        if (rd_addr >= CntW'(MaxRanges))
            rd_addr = '0;
    end

    // Exit conditions of the scans.
    assign collide  = last_req >= rd_start && req_reg.address <= rd_end;
    assign coll_end = !rd_ok_reg && idx_reg >= count_reg;
    assign fit_brk  = rd_ok_reg && cur_reg <= rd_start
        && rd_start - cur_reg >= req_reg.range_length;
    assign fit_end  = (!rd_ok_reg && idx_reg >= count_reg) || fit_brk
        || (rd_ok_reg && rd_end >= cur_reg && rd_end == '1);
    assign find_hit = rd_ok_reg && (req_reg.req_type == REQ_UNMAP
        ? (rd_start == req_reg.address && rd_len == req_reg.range_length)
        : (rd_start <= req_reg.address && req_reg.address - rd_start < rd_len));
    assign shift_more = idx_reg != '0 && rd_start >= place_reg;
    assign del_last   = (idx_reg + CntW'(1)) >= count_reg;

    // Sequencer for the scans and the table updates.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            rd_ok_reg     <= 1'b0;
            cur_reg       <= '0;
            place_reg     <= '0;
            hit_reg       <= 1'b0;
            req_reg       <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (out_valid_reg && !out_stall)
                        out_valid_reg <= 1'b0;
                    if (in_valid && !in_stall)
                    begin
                        req_reg   <= in_data;
                        idx_reg   <= '0;
                        rd_ok_reg <= 1'b0;
                        hit_reg   <= 1'b0;
                        cur_reg   <= win_low_reg;
                        rsp_reg.status        <= ST_INVALID;
                        rsp_reg.result_start  <= '0;
                        rsp_reg.result_length <= in_data.range_length;
                    end
                end
                S_CHECK:
                begin
                    rd_ok_reg <= 1'b0;
                    idx_reg   <= '0;
                    // Default results; the scans overwrite them on success and on some failures.
                    priority if (req_reg.req_type == REQ_UNMAP)
                    begin
                        rsp_reg.status       <= ST_NOTFOUND;
                        rsp_reg.result_start <= req_reg.address;
                    end
                    else if (req_reg.req_type == REQ_LOOKUP)
                    begin
                        rsp_reg.status        <= ST_NOTFOUND;
                        rsp_reg.result_length <= '0;
                    end
                    else if (req_reg.req_type == REQ_MAP && req_reg.range_length != '0
                        && req_reg.placement_mode == MODE_ANY && !hint_fits)
                        rsp_reg.status <= ST_NOSPACE;
                    else
                        rsp_reg.status <= ST_INVALID;
                end
                S_COLL:
                begin
                    // Data for idx arrives in the cycle after it is issued.
                    if (!rd_ok_reg)
                    begin
                        if (coll_end)
                        begin
                            // Without a collision the hint itself is placed.
                            idx_reg <= '0;
                            hit_reg <= 1'b0;
                            cur_reg <= hit_reg ? win_low_reg : req_reg.address;
                            if (hit_reg)
                            begin
                                if (req_reg.placement_mode == MODE_NOREPL)
                                    rsp_reg.status <= ST_EXISTS;
                                else if (req_reg.placement_mode == MODE_FIXED)
                                    rsp_reg.status <= ST_INVALID;
                                else
                                    rsp_reg.status <= ST_NOSPACE;
                            end
                        end
                        else
                            rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        if (collide)
                            hit_reg <= 1'b1;
                        idx_reg <= idx_reg + CntW'(1);
                    end
                end
                S_FIT:
                begin
                    if (!rd_ok_reg)
                    begin
                        if (idx_reg < count_reg)
                            rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        idx_reg   <= idx_reg + CntW'(1);
                        // The cursor only moves forward, past the end of the range.
                        if (!fit_brk && rd_end >= cur_reg)
                            cur_reg <= rd_end + 64'd1;
                    end
                end
                S_FITE:
                begin
                    place_reg      <= cur_reg;
                    rsp_reg.status <= ST_NOSPACE;
                    idx_reg        <= count_reg;
                    rd_ok_reg      <= 1'b0;
                end
                S_SHIFT:
                begin
                    if (!rd_ok_reg)
                        rd_ok_reg <= 1'b1;
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        if (shift_more)
                            idx_reg <= idx_reg - CntW'(1);
                        else
                        begin
                            count_reg <= count_reg + CntW'(1);
                            rsp_reg.status       <= ST_OK;
                            rsp_reg.result_start <= place_reg;
                        end
                    end
                end
                S_FIND:
                begin
                    if (!rd_ok_reg)
                    begin
                        if (idx_reg < count_reg)
                            rd_ok_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        // An unmap hit keeps idx on the entry to remove.
                        if (find_hit)
                        begin
                            rsp_reg.status <= ST_OK;
                            if (req_reg.req_type == REQ_LOOKUP)
                            begin
                                rsp_reg.result_start  <= rd_start;
                                rsp_reg.result_length <= rd_len;
                            end
                        end
                        else
                            idx_reg <= idx_reg + CntW'(1);
                    end
                end
                S_DEL:
                begin
                    if (del_last)
                        count_reg <= count_reg - CntW'(1);
                    else if (!rd_ok_reg)
                        rd_ok_reg <= 1'b1;
                    else
                    begin
                        rd_ok_reg <= 1'b0;
                        idx_reg   <= idx_reg + CntW'(1);
                    end
                end
                S_DONE:
                begin
                    out_valid_reg <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:  if (in_valid && !in_stall) state_next = S_CHECK;
            S_CHECK:
            begin
                if (req_reg.req_type == REQ_UNMAP || req_reg.req_type == REQ_LOOKUP)
                    state_next = S_FIND;
                else if (req_reg.req_type != REQ_MAP || req_reg.range_length == '0
                    || req_reg.placement_mode == MODE_RSVD)
                    state_next = S_DONE;
                else if (!hint_fits)
                    state_next = (req_reg.placement_mode == MODE_ANY) ? S_FIT : S_DONE;
                else
                    state_next = S_COLL;
            end
            S_COLL:
            begin
                if (coll_end)
                begin
                    if (!hit_reg)
                        state_next = S_FITE;
                    else if (req_reg.placement_mode == MODE_ANY)
                        state_next = S_FIT;
                    else
                        state_next = S_DONE;
                end
            end
            S_FIT:
            begin
                if (fit_end)
                begin
                    if (rd_ok_reg && !fit_brk)
                        state_next = S_DONE;
                    else
                        state_next = S_FITE;
                end
            end
            S_FITE:
            begin
                if (!cur_fits || count_reg >= CntW'(MaxRanges))
                    state_next = S_DONE;
                else
                    state_next = S_SHIFT;
            end
            S_SHIFT:
                if (rd_ok_reg && !shift_more)
                    state_next = S_DONE;
            S_FIND:
            begin
                if (!rd_ok_reg && idx_reg >= count_reg)
                    state_next = S_DONE;
                else if (find_hit)
                    state_next = (req_reg.req_type == REQ_UNMAP) ? S_DEL : S_DONE;
            end
            S_DEL:
                if (del_last)
                    state_next = S_DONE;
            S_DONE:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // Memory writes: shift up during insertion, down during removal.
    always_comb
    begin
        we = 1'b0;
        wr_addr = idx_reg[IdxW-1:0];
        wr_start = rd_start;
        wr_len = rd_len;
        if (state_reg == S_SHIFT && rd_ok_reg)
        begin
            we = 1'b1;
            if (!shift_more)
            begin
                wr_start = place_reg;
                wr_len = req_reg.range_length;
            end
        end
        else if (state_reg == S_DEL && rd_ok_reg && !del_last)
            we = 1'b1;
    end

    `ASSERT_IMPL(a_no_accept_busy, clk, rst_n, state_reg != S_IDLE, in_stall)
    `ASSERT_NEXT(a_done_valid, clk, rst_n, state_reg == S_DONE, out_valid)
    `ASSERT_IMPL(a_count_range, clk, rst_n, 1'b1, count_reg <= CntW'(MaxRanges))
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data))

endmodule
